/* src/kto_pkg.sv */
// Shared types and constants for the keyed table with oldest-entry eviction.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package kto_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int TIME_W   = 32;
  localparam int OCC_W    = 6;
  localparam int STATUS_W = 3;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_NOROOM   = 3'd2,
    ST_SWEPT    = 3'd3,
    ST_NONE     = 3'd4
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key_x;
    logic [KEY_W-1:0]  key_z;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    scan_step;
    logic    track;
    logic    restamp;
    logic    shift_start;
    logic    from_best;
    logic    shift_step;
    logic    dec;
    logic    append;
    logic    capture;
    logic    resume;
    logic    emit;
    logic    show;
    logic    last;
    logic    publish;
    status_e status;
    logic    ev_valid;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic match;
    logic expired;
    logic full;
    logic found;
    logic shift_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/kto_datapath.sv */
// Datapath: entry memory, scan pointers, oldest-entry tracking and output register.
// Depends on kto_pkg; driven by commands from kto_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module kto_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [31:0]                  cfg_wdata_i,
  input  wire  signed [31:0]           in_key_x_i,
  input  wire  signed [31:0]           in_key_z_i,
  input  wire  [31:0]                  in_now_i,
  input  wire                          out_stall_i,
  input  kto_pkg::ctl_cmd_t            cmd_i,
  output kto_pkg::dp_status_t          status_o,
  output logic                         out_valid_o,
  output logic [2:0]                   out_status_o,
  output logic                         out_evicted_valid_o,
  output logic signed [31:0]           out_evicted_x_o,
  output logic signed [31:0]           out_evicted_z_o,
  output logic [5:0]                   out_occupancy_o,
  output logic                         out_last_o
);
  import kto_pkg::*;

  entry_t mem [CAPACITY];

  logic [TIME_W-1:0] timeout_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  ptr_q;
  logic [CNT_W-1:0]  resume_q;
  logic              vld_q;
  logic [IDX_W-1:0]  idx_q;
  entry_t            rdata_q;
  entry_t            req_q;
  logic [TIME_W-1:0] best_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              found_q;
  logic [KEY_W-1:0]  ev_x_q;
  logic [KEY_W-1:0]  ev_z_q;

  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_ev_valid_q;
  logic [KEY_W-1:0]  out_x_q;
  logic [KEY_W-1:0]  out_z_q;
  logic [OCC_W-1:0]  out_occ_q;
  logic              out_last_q;

  logic              issue;
  logic              key_eq;
  logic              older;
  logic [TIME_W-1:0] idle;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [IDX_W-1:0]  shift_from;

  assign issue  = (cmd_i.scan_step || cmd_i.shift_step) && (ptr_q < count_q);
  assign key_eq = (rdata_q.key_x == req_q.key_x) && (rdata_q.key_z == req_q.key_z);
  assign older  = rdata_q.stamp < best_q;
  assign idle   = req_q.stamp - rdata_q.stamp;
  assign shift_from = cmd_i.from_best ? best_idx_q : idx_q;

  assign status_o.scan_done  = !vld_q && (ptr_q >= count_q);
  assign status_o.match      = vld_q && key_eq;
  assign status_o.expired    = vld_q && (idle > timeout_q);
  assign status_o.full       = count_q == CNT_W'(CAPACITY);
  assign status_o.found      = found_q;
  assign status_o.shift_done = !vld_q && (ptr_q >= count_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  // One write port: restamp on a hit, append a new key, or move an entry down.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = req_q;
    if (cmd_i.restamp) begin
      wr_en   = 1'b1;
      wr_addr = idx_q;
    end else if (cmd_i.append) begin
      wr_en   = 1'b1;
      wr_addr = count_q[IDX_W-1:0];
    end else if (cmd_i.shift_step && vld_q) begin
      wr_en   = 1'b1;
      wr_addr = idx_q - IDX_W'(1);
      wr_data = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata_q <= mem[ptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end else if (cmd_i.dec) begin
        count_q <= count_q - CNT_W'(1);
      end
      priority if (cmd_i.shift_start) begin
        ptr_q <= CNT_W'(shift_from) + CNT_W'(1);
        vld_q <= 1'b0;
      end else if (cmd_i.resume) begin
        ptr_q <= resume_q;
        vld_q <= 1'b0;
      end else if (cmd_i.load) begin
        ptr_q <= '0;
        vld_q <= 1'b0;
      end else if (cmd_i.scan_step || cmd_i.shift_step) begin
        vld_q <= issue;
        if (issue) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
      end else begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      idx_q <= ptr_q[IDX_W-1:0];
    end
    if (cmd_i.load) begin
      req_q.key_x <= $unsigned(in_key_x_i);
      req_q.key_z <= $unsigned(in_key_z_i);
      req_q.stamp <= in_now_i;
      best_q      <= '1;
    end else if (cmd_i.track && vld_q && older) begin
      best_q     <= rdata_q.stamp;
      best_idx_q <= idx_q;
      ev_x_q     <= rdata_q.key_x;
      ev_z_q     <= rdata_q.key_z;
    end else if (cmd_i.capture) begin
      ev_x_q   <= rdata_q.key_x;
      ev_z_q   <= rdata_q.key_z;
      resume_q <= CNT_W'(idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (cmd_i.track && vld_q && older) begin
      found_q <= 1'b1;
    end
  end

  // Output register. A staged sweep result waits here with valid low until
  // the controller knows whether it is the final one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= cmd_i.show;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q   <= cmd_i.status;
      out_ev_valid_q <= cmd_i.ev_valid;
      out_x_q        <= cmd_i.ev_valid ? ev_x_q : '0;
      out_z_q        <= cmd_i.ev_valid ? ev_z_q : '0;
      out_occ_q      <= OCC_W'(count_q);
      out_last_q     <= cmd_i.last;
    end else if (cmd_i.publish && cmd_i.last) begin
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_evicted_valid_o = out_ev_valid_q;
  assign out_evicted_x_o     = $signed(out_x_q);
  assign out_evicted_z_o     = $signed(out_z_q);
  assign out_occupancy_o     = out_occ_q;
  assign out_last_o          = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while a result waits");

  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> (count_q < CNT_W'(CAPACITY)))
    else $error("append into a full table");

  a_shift_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift_step && vld_q) |-> (idx_q != '0))
    else $error("compaction move from the first entry");

  a_publish_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> !out_valid_q)
    else $error("publish without a staged result");

endmodule

`default_nettype wire

/* src/kto_ctrl.sv */
// Controller: sequences scan, compaction, append and result delivery.
// Depends on kto_pkg; drives kto_datapath through command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module kto_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_func_i,
  output logic                 in_stall_o,
  input  kto_pkg::dp_status_t  status_i,
  output kto_pkg::ctl_cmd_t    cmd_o
);
  import kto_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ACC_SCAN = 4'd1;
  localparam logic [3:0] S_SHIFT    = 4'd2;
  localparam logic [3:0] S_APPEND   = 4'd3;
  localparam logic [3:0] S_EMIT     = 4'd4;
  localparam logic [3:0] S_SW_SCAN  = 4'd5;
  localparam logic [3:0] S_SW_PUB   = 4'd6;
  localparam logic [3:0] S_SW_STAGE = 4'd7;

  logic [3:0] state_q, state_d;
  status_e    status_q, status_d;
  logic       ev_q, ev_d;
  logic       pend_q, pend_d;
  logic       func_q, func_d;

  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    ev_d     = ev_q;
    pend_d   = pend_q;
    func_d   = func_q;
    cmd_o    = '0;
    cmd_o.status = ST_HIT;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          func_d     = in_func_i;
          ev_d       = 1'b0;
          pend_d     = 1'b0;
          state_d    = in_func_i ? S_SW_SCAN : S_ACC_SCAN;
        end
      end
      S_ACC_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.track     = 1'b1;
        if (status_i.match) begin
          cmd_o.restamp = 1'b1;
          status_d      = ST_HIT;
          state_d       = S_EMIT;
        end else if (status_i.scan_done) begin
          if (!status_i.full) begin
            state_d = S_APPEND;
          end else if (!status_i.found) begin
            status_d = ST_NOROOM;
            state_d  = S_EMIT;
          end else begin
            cmd_o.shift_start = 1'b1;
            cmd_o.from_best   = 1'b1;
            ev_d              = 1'b1;
            state_d           = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (status_i.shift_done) begin
          cmd_o.dec = 1'b1;
          state_d   = func_q ? S_SW_PUB : S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        status_d     = ST_INSERTED;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.show     = 1'b1;
          cmd_o.last     = 1'b1;
          cmd_o.status   = status_q;
          cmd_o.ev_valid = ev_q;
          state_d        = S_IDLE;
        end
      end
      S_SW_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.expired) begin
          cmd_o.capture     = 1'b1;
          cmd_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end else if (status_i.scan_done) begin
          if (pend_q) begin
            cmd_o.publish = 1'b1;
            cmd_o.last    = 1'b1;
            state_d       = S_IDLE;
          end else begin
            status_d = ST_NONE;
            ev_d     = 1'b0;
            state_d  = S_EMIT;
          end
        end
      end
      S_SW_PUB: begin
        // A later removal exists, so the staged one is not the final result.
        cmd_o.publish = pend_q;
        state_d       = S_SW_STAGE;
      end
      S_SW_STAGE: begin
        if (status_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.status   = ST_SWEPT;
          cmd_o.ev_valid = 1'b1;
          cmd_o.resume   = 1'b1;
          pend_d         = 1'b1;
          state_d        = S_SW_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_HIT;
      ev_q     <= 1'b0;
      pend_q   <= 1'b0;
      func_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      ev_q     <= ev_d;
      pend_q   <= pend_d;
      func_q   <= func_d;
    end
  end

endmodule

`default_nettype wire

/* src/keyed_table_oldest_eviction.sv */
// An access scans until a key match or the end of the table; an eviction adds a compaction pass.
// A sweep scans the whole table, with a compaction pass and a staged result for each removal.
// Throughput: one request at a time; the single read port of the entry memory sets the pace.
// Reset clears the entry count, the controller and the output valid; the timeout returns to 60.
// Entry contents are not cleared: only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module keyed_table_oldest_eviction (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [31:0]         cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 in_func_i,
  input  wire  signed [31:0]  in_key_x_i,
  input  wire  signed [31:0]  in_key_z_i,
  input  wire  [31:0]         in_now_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [2:0]          out_status_o,
  output logic                out_evicted_valid_o,
  output logic signed [31:0]  out_evicted_x_o,
  output logic signed [31:0]  out_evicted_z_o,
  output logic [5:0]          out_occupancy_o,
  output logic                out_last_o
);
  import kto_pkg::*;

  // The controller walks the table one entry per cycle through the memory's
  // read port. An access request looks for its key while it keeps track of
  // the oldest stamp; a miss on a full table removes that entry by moving the
  // later entries down, one per cycle, and then appends the new key.
  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  kto_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_func_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // A sweep request stages each removal in the output register and shows it
  // only once the next removal or the end of the table is found, so that the
  // final result of the request carries the last flag.
  kto_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_key_x_i          (in_key_x_i),
    .in_key_z_i          (in_key_z_i),
    .in_now_i            (in_now_i),
    .out_stall_i         (out_stall_i),
    .cmd_i               (cmd),
    .status_o            (dp_status),
    .out_valid_o         (out_valid_o),
    .out_status_o        (out_status_o),
    .out_evicted_valid_o (out_evicted_valid_o),
    .out_evicted_x_o     (out_evicted_x_o),
    .out_evicted_z_o     (out_evicted_z_o),
    .out_occupancy_o     (out_occupancy_o),
    .out_last_o          (out_last_o)
  );

endmodule

`default_nettype wire
